>>> design/phfa_pkg.sv
// Package for the paired half-precision adder: item types, instruction codes
// and the float conversion and rounding functions shared by the stages.
// No dependencies.
package phfa_pkg;

  typedef enum logic [1:0] {FORM_REG, FORM_CBUF, FORM_IMM9, FORM_IMM32} form_e;
  typedef enum logic [1:0] {SWZ_H0H1, SWZ_F32, SWZ_H0, SWZ_H1} swz_e;
  typedef enum logic [1:0] {MERGE_PACK, MERGE_F32, MERGE_LO, MERGE_HI} merge_e;

  localparam logic [15:0] HALF_NAN = 16'h7E00;
  localparam logic [15:0] HALF_ONE = 16'h3C00;
  localparam logic [31:0] F32_NAN  = 32'h7FC00000;
  localparam logic [31:0] F32_ONE  = 32'h3F800000;
  localparam logic [7:0]  ALIGN_MAX = 8'd26;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] insn_word;
    logic [31:0] a_operand;
    logic [31:0] b_operand;
    logic [31:0] dest_old;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic [7:0]  dest_index;
  } out_item_t;

  typedef struct packed {
    logic fpath;
    logic ftz;
    logic sat;
  } lane_ctl_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } lane_op_t;

  typedef struct packed {
    merge_e      merge;
    logic [31:0] dest_old;
    logic [7:0]  dest;
  } side_t;

  typedef struct packed {
    lane_op_t  lo;
    lane_op_t  hi;
    lane_ctl_t ctl;
    side_t     side;
  } dec_t;

  typedef struct packed {
    logic [50:0] sum;
    logic [7:0]  exp;
    logic        sign;
    logic        nan;
    logic        inf;
    lane_ctl_t   ctl;
  } add_st_t;

  typedef struct packed {
    logic [50:0] mant;
    logic [9:0]  uexp;
    logic        sign;
    logic        zero;
    logic        nan;
    logic        inf;
    lane_ctl_t   ctl;
  } norm_st_t;

  typedef struct packed {
    logic [31:0] val;
    logic        nan;
    logic        fpath;
  } lane_res_t;

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [3:0]  lz;
    logic [9:0]  fn;
    logic [31:0] r;
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h[i]) lz = 4'(9 - i);
    end
    fn = h[9:0] << (lz + 4'd1);
    if (h[14:10] == 5'h1F) begin
      r = (h[9:0] != 10'd0) ? F32_NAN : {h[15], 8'hFF, 23'd0};
    end else if (h[14:10] == 5'd0) begin
      r = (h[9:0] == 10'd0) ? {h[15], 31'd0} : {h[15], 8'd112 - {4'd0, lz}, fn, 13'd0};
    end else begin
      r = {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
    end
    return r;
  endfunction

  function automatic logic [15:0] half_ftz(input logic [15:0] h);
    return (h[14:10] == 5'd0) ? {h[15], 15'd0} : h;
  endfunction

  function automatic logic [31:0] f32_ftz(input logic [31:0] f);
    return (f[30:23] == 8'd0) ? {f[31], 31'd0} : f;
  endfunction

  // n is normalized with its leading one at bit 50; ue is the unbiased exponent
  function automatic logic [14:0] round_half(input logic [50:0] n, input logic [9:0] ue);
    logic [5:0]   sh;
    logic [114:0] t;
    logic [10:0]  q;
    logic         g;
    logic         s;
    logic [4:0]   ef;
    logic [14:0]  r;
    if ($signed(ue) >= -10'sd14) begin
      sh = 6'd0;
      ef = 5'($signed(ue) + 10'sd15);
    end else begin
      sh = ($signed(ue) < -10'sd77) ? 6'd63 : 6'(-10'sd14 - $signed(ue));
      ef = 5'd0;
    end
    t = {n, 64'd0} >> sh;
    q = t[114:104];
    g = t[103];
    s = |t[102:0];
    r = {ef, q[9:0]} + {14'd0, g & (s | q[0])};
    if ($signed(ue) > 10'sd15) r = 15'h7C00;
    return r;
  endfunction

  function automatic logic [30:0] round_f32(input logic [50:0] n, input logic [9:0] ue);
    logic [5:0]   sh;
    logic [114:0] t;
    logic [23:0]  q;
    logic         g;
    logic         s;
    logic [7:0]   ef;
    logic [30:0]  r;
    if ($signed(ue) >= -10'sd126) begin
      sh = 6'd0;
      ef = 8'($signed(ue) + 10'sd127);
    end else begin
      sh = ($signed(ue) < -10'sd189) ? 6'd63 : 6'(-10'sd126 - $signed(ue));
      ef = 8'd0;
    end
    t = {n, 64'd0} >> sh;
    q = t[114:91];
    g = t[90];
    s = |t[89:0];
    r = {ef, q[22:0]} + {30'd0, g & (s | q[0])};
    if ($signed(ue) > 10'sd127) r = 31'h7F800000;
    return r;
  endfunction

  function automatic logic [15:0] f32_to_half(input logic [31:0] f);
    logic [15:0] r;
    if (f[30:23] == 8'hFF) begin
      r = {f[31], 15'h7C00};
    end else if (f[30:23] == 8'd0) begin
      r = {f[31], 15'd0};
    end else begin
      r = {f[31], round_half({1'b1, f[22:0], 27'd0}, 10'({2'b00, f[30:23]}) - 10'd127)};
    end
    return r;
  endfunction

  function automatic logic [5:0] lzc51(input logic [50:0] v);
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) lz = 6'(50 - i);
    end
    return lz;
  endfunction

endpackage

>>> design/packed_half_float_add_unit.sv
// Top level of the paired half-precision adder: decode stage, two lanes,
// pack stage and output register. Depends on phfa_pkg and all phfa_ modules.
//
//   channel | dir | handshake               | payload
//   in      | in  | in_valid_i / in_ready_o | in_item_i  (phfa_pkg::in_item_t)
//   out     | out | out_valid_o/out_ready_i | out_item_o (phfa_pkg::out_item_t)
//
// Five register stages: decode, align/add, normalize, round, pack into the
// output register; one item is taken every cycle unless all five are held.
// Reset clears the stage valid bits only.
// A stage holds while the stage ahead is full and held; empty stages fill
// in, so a stalled output blocks the input only when all five are full.
module packed_half_float_add_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  phfa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phfa_pkg::out_item_t out_item_o
);
  import phfa_pkg::*;

  logic [4:0] vld_q;
  logic [4:0] en;
  dec_t       dec_d;
  dec_t       dec_q;
  side_t      side2_q;
  side_t      side3_q;
  side_t      side4_q;
  lane_res_t  lo_res;
  lane_res_t  hi_res;
  out_item_t  out_d;
  out_item_t  out_q;

  always_comb begin
    en[4] = !vld_q[4] || out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  phfa_decode u_decode (
    .in_i  (in_item_i),
    .dec_o (dec_d)
  );

  phfa_lane u_lane_lo (
    .clk_i (clk_i),
    .en_i  (en[3:1]),
    .op_i  (dec_q.lo),
    .ctl_i (dec_q.ctl),
    .res_o (lo_res)
  );

  phfa_lane u_lane_hi (
    .clk_i (clk_i),
    .en_i  (en[3:1]),
    .op_i  (dec_q.hi),
    .ctl_i (dec_q.ctl),
    .res_o (hi_res)
  );

  phfa_pack u_pack (
    .lo_i   (lo_res),
    .hi_i   (hi_res),
    .side_i (side4_q),
    .out_o  (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 5'd0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) dec_q <= dec_d;
    if (en[1]) side2_q <= dec_q.side;
    if (en[2]) side3_q <= side2_q;
    if (en[3]) side4_q <= side3_q;
    if (en[4]) out_q <= out_d;
  end

  assign out_valid_o = vld_q[4];
  assign out_item_o  = out_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item did not enter the decode stage");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> in_ready_o)
    else $error("empty decode stage refused an item");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !out_ready_i |-> !in_ready_o)
    else $error("full stalled pipeline took an item");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !vld_q[3] |=> !out_valid_o)
    else $error("output item repeated");

endmodule

>>> design/phfa_decode.sv
// Instruction decode and lane setup: selects lanes, promotes to float32,
// applies abs, negate and flush-to-zero. Depends on phfa_pkg.
module phfa_decode (
  input  phfa_pkg::in_item_t in_i,
  output phfa_pkg::dec_t     dec_o
);
  import phfa_pkg::*;

  logic [63:0] w;
  form_e       form;
  merge_e      merge;
  swz_e        swz_a;
  swz_e        swz_b;
  logic        ftz;
  logic        sat;
  logic        neg_a;
  logic        abs_a;
  logic        neg_b;
  logic        abs_b;
  logic [31:0] bval;
  logic [31:0] la;
  logic [31:0] ha;
  logic [31:0] lb;
  logic [31:0] hb;
  logic        fa;
  logic        fb;
  logic        fpath;

  function automatic logic [31:0] pick(input logic [31:0] v, input swz_e s, input logic hi);
    logic [31:0] r;
    case (s)
      SWZ_H0H1: r = hi ? {16'd0, v[31:16]} : {16'd0, v[15:0]};
      SWZ_F32:  r = v;
      SWZ_H0:   r = {16'd0, v[15:0]};
      SWZ_H1:   r = {16'd0, v[31:16]};
      default:  r = v;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] prep(input logic [31:0] raw, input logic is_f,
                                       input logic fp, input logic ab, input logic ng,
                                       input logic fz);
    logic [31:0] x;
    logic [15:0] h;
    if (fp) begin
      x = is_f ? raw : half_to_f32(raw[15:0]);
      if (ab) x[31] = 1'b0;
      if (ng) x[31] = ~x[31];
      if (fz) x = f32_ftz(x);
    end else begin
      h = raw[15:0];
      if (ab) h[15] = 1'b0;
      if (ng) h[15] = ~h[15];
      if (fz) h = half_ftz(h);
      x = half_to_f32(h);
    end
    return x;
  endfunction

  always_comb begin
    w     = in_i.insn_word;
    form  = form_e'(in_i.req_type);
    merge = merge_e'(w[50:49]);
    ftz   = w[39];
    neg_a = w[43];
    abs_a = w[44];
    swz_a = swz_e'(w[48:47]);
    swz_b = SWZ_H0H1;
    sat   = w[52];
    abs_b = 1'b0;
    neg_b = 1'b0;
    bval  = in_i.b_operand;
    case (form)
      FORM_REG: begin
        sat   = w[32];
        neg_b = w[31];
        abs_b = w[30];
        swz_b = swz_e'(w[29:28]);
      end
      FORM_CBUF: begin
        neg_b = w[56];
        abs_b = w[54];
        swz_b = SWZ_F32;
      end
      FORM_IMM9: begin
        bval = {w[56], w[38:30], 6'd0, w[29], w[28:20], 6'd0};
      end
      FORM_IMM32: begin
        merge = MERGE_PACK;
        ftz   = w[55];
        neg_a = w[56];
        abs_a = 1'b0;
        swz_a = swz_e'(w[54:53]);
        bval  = w[51:20];
      end
      default: begin
      end
    endcase

    la    = pick(in_i.a_operand, swz_a, 1'b0);
    ha    = pick(in_i.a_operand, swz_a, 1'b1);
    lb    = pick(bval, swz_b, 1'b0);
    hb    = pick(bval, swz_b, 1'b1);
    fa    = (swz_a == SWZ_F32);
    fb    = (swz_b == SWZ_F32);
    fpath = fa | fb;

    dec_o.lo.a          = prep(la, fa, fpath, abs_a, neg_a, ftz);
    dec_o.hi.a          = prep(ha, fa, fpath, abs_a, neg_a, ftz);
    dec_o.lo.b          = prep(lb, fb, fpath, abs_b, neg_b, ftz);
    dec_o.hi.b          = prep(hb, fb, fpath, abs_b, neg_b, ftz);
    dec_o.ctl.fpath     = fpath;
    dec_o.ctl.ftz       = ftz;
    dec_o.ctl.sat       = sat;
    dec_o.side.merge    = merge;
    dec_o.side.dest_old = in_i.dest_old;
    dec_o.side.dest     = w[7:0];
  end

endmodule

>>> design/phfa_lane.sv
// One adder lane, three register stages: align and add, normalize, round
// with flush-to-zero and saturate. Depends on phfa_pkg.
module phfa_lane (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  phfa_pkg::lane_op_t  op_i,
  input  phfa_pkg::lane_ctl_t ctl_i,
  output phfa_pkg::lane_res_t res_o
);
  import phfa_pkg::*;

  add_st_t   add_d;
  add_st_t   add_q;
  norm_st_t  norm_d;
  norm_st_t  norm_q;
  lane_res_t res_d;
  lane_res_t res_q;

  logic [7:0]  ea;
  logic [7:0]  eb;
  logic [23:0] ma;
  logic [23:0] mb;
  logic        nan_a;
  logic        nan_b;
  logic        inf_a;
  logic        inf_b;
  logic        a_big;
  logic [7:0]  e_big;
  logic [7:0]  e_sml;
  logic [23:0] m_big;
  logic [23:0] m_sml;
  logic [7:0]  shamt;
  logic [49:0] big;
  logic [49:0] sml;
  logic [50:0] sum;
  logic [5:0]  lz;
  logic [31:0] f;
  logic [15:0] h;

  always_comb begin
    ea    = (op_i.a[30:23] == 8'd0) ? 8'd1 : op_i.a[30:23];
    eb    = (op_i.b[30:23] == 8'd0) ? 8'd1 : op_i.b[30:23];
    ma    = {op_i.a[30:23] != 8'd0, op_i.a[22:0]};
    mb    = {op_i.b[30:23] != 8'd0, op_i.b[22:0]};
    nan_a = (&op_i.a[30:23]) & (|op_i.a[22:0]);
    nan_b = (&op_i.b[30:23]) & (|op_i.b[22:0]);
    inf_a = (&op_i.a[30:23]) & ~(|op_i.a[22:0]);
    inf_b = (&op_i.b[30:23]) & ~(|op_i.b[22:0]);
    a_big = {ea, ma} >= {eb, mb};
    e_big = a_big ? ea : eb;
    e_sml = a_big ? eb : ea;
    m_big = a_big ? ma : mb;
    m_sml = a_big ? mb : ma;
    shamt = e_big - e_sml;
    big   = {m_big, 26'd0};
    if (shamt > ALIGN_MAX) sml = {49'd0, |m_sml};
    else sml = {m_sml, 26'd0} >> shamt;
    if (op_i.a[31] ^ op_i.b[31]) sum = {1'b0, big} - {1'b0, sml};
    else sum = {1'b0, big} + {1'b0, sml};

    add_d.sum  = sum;
    add_d.exp  = e_big;
    add_d.nan  = nan_a | nan_b | (inf_a & inf_b & (op_i.a[31] ^ op_i.b[31]));
    add_d.inf  = inf_a | inf_b;
    add_d.ctl  = ctl_i;
    if (inf_a | inf_b) add_d.sign = inf_a ? op_i.a[31] : op_i.b[31];
    else if (sum == 51'd0) add_d.sign = op_i.a[31] & op_i.b[31];
    else add_d.sign = a_big ? op_i.a[31] : op_i.b[31];
  end

  always_comb begin
    lz          = lzc51(add_q.sum);
    norm_d.mant = add_q.sum << lz;
    norm_d.uexp = 10'({2'b00, add_q.exp}) - 10'd126 - 10'({4'd0, lz});
    norm_d.sign = add_q.sign;
    norm_d.zero = (add_q.sum == 51'd0);
    norm_d.nan  = add_q.nan;
    norm_d.inf  = add_q.inf;
    norm_d.ctl  = add_q.ctl;
  end

  always_comb begin
    f           = 32'd0;
    h           = 16'd0;
    res_d.nan   = 1'b0;
    res_d.fpath = norm_q.ctl.fpath;
    if (norm_q.ctl.fpath) begin
      if (norm_q.inf) f = {norm_q.sign, 8'hFF, 23'd0};
      else if (norm_q.zero) f = {norm_q.sign, 31'd0};
      else f = {norm_q.sign, round_f32(norm_q.mant, norm_q.uexp)};
      if (norm_q.ctl.ftz) f = f32_ftz(f);
      if (norm_q.ctl.sat) begin
        if (f[31] || f == 32'd0) f = 32'd0;
        else if (f > F32_ONE) f = F32_ONE;
      end
      res_d.nan = norm_q.nan;
      res_d.val = f;
    end else begin
      if (norm_q.nan) h = HALF_NAN;
      else if (norm_q.inf) h = {norm_q.sign, 15'h7C00};
      else if (norm_q.zero) h = {norm_q.sign, 15'd0};
      else h = {norm_q.sign, round_half(norm_q.mant, norm_q.uexp)};
      if (norm_q.ctl.ftz) h = half_ftz(h);
      if (norm_q.ctl.sat) begin
        if (h == HALF_NAN || h[15] || h == 16'd0) h = 16'd0;
        else if (h > HALF_ONE) h = HALF_ONE;
      end
      res_d.val = {16'd0, h};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) add_q <= add_d;
    if (en_i[1]) norm_q <= norm_d;
    if (en_i[2]) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> design/phfa_pack.sv
// Result packing: narrows float32 lane sums to half and merges the lanes
// into the destination word or widens the low lane. Depends on phfa_pkg.
module phfa_pack (
  input  phfa_pkg::lane_res_t lo_i,
  input  phfa_pkg::lane_res_t hi_i,
  input  phfa_pkg::side_t     side_i,
  output phfa_pkg::out_item_t out_o
);
  import phfa_pkg::*;

  logic [15:0] lo_h;
  logic [15:0] hi_h;

  always_comb begin
    if (lo_i.fpath) lo_h = lo_i.nan ? HALF_NAN : f32_to_half(lo_i.val);
    else lo_h = lo_i.val[15:0];
    if (hi_i.fpath) hi_h = hi_i.nan ? HALF_NAN : f32_to_half(hi_i.val);
    else hi_h = hi_i.val[15:0];
    case (side_i.merge)
      MERGE_PACK: out_o.result_word = {hi_h, lo_h};
      MERGE_F32:  out_o.result_word = half_to_f32(lo_h);
      MERGE_LO:   out_o.result_word = {side_i.dest_old[31:16], lo_h};
      MERGE_HI:   out_o.result_word = {hi_h, side_i.dest_old[15:0]};
      default:    out_o.result_word = {hi_h, lo_h};
    endcase
    out_o.dest_index = side_i.dest;
  end

endmodule

>>> dv/tb_packed_half_float_add_unit.sv
// Testbench for packed_half_float_add_unit: drives instruction items, predicts
// each paired fp16 add result and checks the outputs in order.
// Depends on phfa_pkg and the RTL of packed_half_float_add_unit.
`timescale 1ns / 100ps

module tb_packed_half_float_add_unit;
  import phfa_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  stim_q[$];
  out_item_t sum_q[$];
  logic      in_fire = 1'b0;
  int        sent_cnt = 0;
  int        recv_cnt = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        gap_cnt = 0;
  int        stall_cnt = 0;
  int        hold_cnt = 0;
  bit        drained = 0;
  bit        held = 0;

  packed_half_float_add_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic real to_real(logic [31:0] v, int fb, int ew);
    int          bias;
    int          e;
    int          f;
    logic        s;
    real         x;
    logic [51:0] frac;
    bias = (1 << (ew - 1)) - 1;
    s = v[fb + ew];
    e = int'((v >> fb) & ((32'd1 << ew) - 1));
    f = int'(v & ((32'd1 << fb) - 1));
    if (e == (1 << ew) - 1) begin
      return (f != 0) ? $bitstoreal(64'h7FF8000000000000) : $bitstoreal({s, 11'h7FF, 52'd0});
    end
    if (e == 0) begin
      x = real'(f) / (2.0 ** (bias + fb - 1));
      return s ? -x : x;
    end
    frac = 52'(f) << (52 - fb);
    return $bitstoreal({s, 11'(e - bias + 1023), frac});
  endfunction

  // round a double to nearest even in a format with fb fraction and ew exponent bits
  function automatic logic [31:0] round_to_fmt(real d, int fb, int ew);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] hv;
    logic [31:0] sgn;
    logic [31:0] infb;
    int          bias;
    int          e;
    int          ex;
    int          sh;
    b = $realtobits(d);
    bias = (1 << (ew - 1)) - 1;
    sgn = 32'(b[63]) << (fb + ew);
    infb = 32'((1 << ew) - 1) << fb;
    e = int'(b[62:52]);
    if (e == 2047) return (b[51:0] != 0) ? (infb | (32'd1 << (fb - 1))) : (sgn | infb);
    if (e == 0) return sgn;
    ex = e - 1023;
    if (ex > bias) return sgn | infb;
    if (ex < -bias - fb) return sgn;
    m = {12'd1, b[51:0]};
    sh = (ex >= 1 - bias) ? 52 - fb : 52 - fb + (1 - bias - ex);
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    hv = 64'd1 << (sh - 1);
    if (rem > hv || (rem == hv && q[0])) q = q + 1;
    if (ex >= 1 - bias) return sgn | ((32'(ex + bias - 1) << fb) + 32'(q));
    return sgn | 32'(q);
  endfunction

  function automatic logic [31:0] flush_sub(logic [31:0] v, int fb, int ew);
    if (((v >> fb) & ((32'd1 << ew) - 1)) == 0) return v & (32'd1 << (fb + ew));
    return v;
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    return round_to_fmt(to_real({16'd0, h}, 10, 5), 23, 8);
  endfunction

  function automatic logic [31:0] sign_op(logic [31:0] v, int pos, logic ab, logic ng);
    if (ab) v[pos] = 1'b0;
    if (ng) v[pos] = ~v[pos];
    return v;
  endfunction

  function automatic logic split_lanes(logic [31:0] w, swz_e sw,
                                       output logic [31:0] lo, output logic [31:0] hi);
    case (sw)
      SWZ_H0H1: begin lo = {16'd0, w[15:0]};  hi = {16'd0, w[31:16]}; end
      SWZ_F32:  begin lo = w;                 hi = w; end
      SWZ_H0:   begin lo = {16'd0, w[15:0]};  hi = {16'd0, w[15:0]}; end
      default:  begin lo = {16'd0, w[31:16]}; hi = {16'd0, w[31:16]}; end
    endcase
    return sw == SWZ_F32;
  endfunction

  function automatic logic [15:0] lane_sum(logic [31:0] a, logic [31:0] b, logic fpath,
                                           logic ftz, logic sat);
    int          fb;
    int          ew;
    logic [31:0] r;
    logic [31:0] one;
    logic        nan;
    fb = fpath ? 23 : 10;
    ew = fpath ? 8 : 5;
    one = fpath ? F32_ONE : {16'd0, HALF_ONE};
    if (ftz) begin
      a = flush_sub(a, fb, ew);
      b = flush_sub(b, fb, ew);
    end
    r = round_to_fmt(to_real(a, fb, ew) + to_real(b, fb, ew), fb, ew);
    nan = (((r >> fb) & ((32'd1 << ew) - 1)) == (32'd1 << ew) - 1) &&
          ((r & ((32'd1 << fb) - 1)) != 0);
    if (nan) return (sat && !fpath) ? 16'd0 : HALF_NAN;
    if (ftz) r = flush_sub(r, fb, ew);
    if (sat) begin
      if (r[fb + ew] || r == 0) r = 0;
      else if (r > one) r = one;
    end
    return fpath ? round_to_fmt(to_real(r, 23, 8), 10, 5) : r[15:0];
  endfunction

  function automatic out_item_t predict_sum(in_item_t it);
    logic [63:0] w;
    form_e       form;
    merge_e      mrg;
    swz_e        sa;
    swz_e        sb;
    logic        ftz, sat, na, aa, nb, ab, fa, fb, fp;
    logic [31:0] bv, la, ha, lb, hb;
    logic [15:0] lo, hi;
    int          pos;
    out_item_t   r;
    w = it.insn_word;
    form = form_e'(it.req_type);
    mrg = merge_e'(w[50:49]);
    ftz = w[39];
    na = w[43];
    aa = w[44];
    sa = swz_e'(w[48:47]);
    sb = SWZ_H0H1;
    sat = w[52];
    ab = 1'b0;
    nb = 1'b0;
    bv = it.b_operand;
    case (form)
      FORM_REG: begin
        sat = w[32];
        nb = w[31];
        ab = w[30];
        sb = swz_e'(w[29:28]);
      end
      FORM_CBUF: begin
        nb = w[56];
        ab = w[54];
        sb = SWZ_F32;
      end
      FORM_IMM9: bv = {w[56], w[38:30], 6'd0, w[29], w[28:20], 6'd0};
      default: begin
        mrg = MERGE_PACK;
        ftz = w[55];
        na = w[56];
        aa = 1'b0;
        sa = swz_e'(w[54:53]);
        bv = w[51:20];
      end
    endcase
    fa = split_lanes(it.a_operand, sa, la, ha);
    fb = split_lanes(bv, sb, lb, hb);
    fp = fa || fb;
    if (fp) begin
      if (!fa) begin la = widen_half(la[15:0]); ha = widen_half(ha[15:0]); end
      if (!fb) begin lb = widen_half(lb[15:0]); hb = widen_half(hb[15:0]); end
    end
    pos = fp ? 31 : 15;
    lo = lane_sum(sign_op(la, pos, aa, na), sign_op(lb, pos, ab, nb), fp, ftz, sat);
    hi = lane_sum(sign_op(ha, pos, aa, na), sign_op(hb, pos, ab, nb), fp, ftz, sat);
    case (mrg)
      MERGE_PACK: r.result_word = {hi, lo};
      MERGE_F32:  r.result_word = widen_half(lo);
      MERGE_LO:   r.result_word = {it.dest_old[31:16], lo};
      default:    r.result_word = {hi, it.dest_old[15:0]};
    endcase
    r.dest_index = w[7:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_half();
    logic [15:0] specials[12] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01,
                                  16'h3C00, 16'h0001, 16'h03FF, 16'h7BFF, 16'h0400, 16'hBC00};
    case ($urandom_range(0, 9))
      0, 1:    return specials[$urandom_range(0, 11)];
      2:       return {1'($urandom), 5'd0, 10'($urandom)};
      3, 4, 5: return {1'($urandom), 5'($urandom_range(12, 17)), 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return {1'($urandom), 8'($urandom_range(100, 145)), 23'($urandom)};
      1:       return $urandom;
      default: return {pick_half(), pick_half()};
    endcase
  endfunction

  task automatic add_item(logic [1:0] rt, logic [63:0] w, logic [31:0] a, logic [31:0] b);
    in_item_t it;
    it.req_type = rt;
    it.insn_word = w;
    it.a_operand = a;
    it.b_operand = b;
    it.dest_old = $urandom;
    stim_q.push_back(it);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (sent_cnt == 600 && !drained) begin
        in_valid <= 1'b0;
        if (sum_q.size() == 0) drained = 1;
      end else if (gap_cnt > 0) begin
        gap_cnt--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 150 && $urandom_range(0, 7) == 0) begin
        gap_cnt = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        in_item <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_cnt == 300 && !held) begin
        held = 1;
        hold_cnt = 60;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else if (stim_q.size() > 150 && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    cycles++;
    if (cycles > 400000) begin
      $display("** packed_half_float_add_unit: FAILED **");
      $finish;
    end
    if (rst_ni) begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        sum_q.push_back(predict_sum(in_item));
        sent_cnt++;
      end
      if (out_valid && out_ready) begin
        recv_cnt++;
        if (sum_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %h %h", out_item.result_word,
                                         out_item.dest_index);
        end else begin
          want = sum_q.pop_front();
          if (want.result_word !== out_item.result_word ||
              want.dest_index !== out_item.dest_index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: result exp %h got %h, dest exp %h got %h",
                       want.result_word, out_item.result_word,
                       want.dest_index, out_item.dest_index);
            end
          end
        end
      end
    end
  end

  initial begin
    logic [63:0] w;
    for (int f = 0; f < 4; f++) begin
      for (int s = 0; s < 4; s++) begin
        w = {$urandom, $urandom};
        w[48:47] = 2'(s);
        w[50:49] = 2'(s);
        w[29:28] = 2'(s);
        w[54:53] = 2'(s);
        add_item(2'(f), w, pick_word(), pick_word());
      end
    end
    w = 64'hA5;
    add_item(FORM_REG, w, 32'h7BFF7BFF, 32'h7BFF7BFF);
    add_item(FORM_REG, w, 32'h7C00FC00, 32'hFC007C00);
    add_item(FORM_REG, w, 32'h80008000, 32'h80008000);
    add_item(FORM_REG, w | (64'd1 << 44) | (64'd1 << 43), 32'h7E01FE00, 32'h3C003C00);
    add_item(FORM_REG, w | (64'd1 << 39), 32'h00018001, 32'h03FF0000);
    add_item(FORM_REG, w | (64'd1 << 32), 32'h3C00BC00, 32'h3C007E00);
    add_item(FORM_CBUF, w | (64'd1 << 49), 32'h7BFF0001, 32'h7F7FFFFF);
    add_item(FORM_IMM32, w | (64'd1 << 55) | (64'd1 << 52) | (64'h00013C01 << 20),
             32'h80013C00, 32'h0);
    for (int i = 0; i < 1250; i++) begin
      w = {$urandom, $urandom};
      if ($urandom_range(0, 1)) w[51:20] = {pick_half(), pick_half()};
      add_item(2'($urandom_range(0, 3)), w, pick_word(), pick_word());
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (stim_q.size() != 0 || in_valid || sum_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** packed_half_float_add_unit: PASSED **");
    end else begin
      $display("** packed_half_float_add_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
design/phfa_pkg.sv
design/phfa_decode.sv
design/phfa_lane.sv
design/phfa_pack.sv
design/packed_half_float_add_unit.sv
dv/tb_packed_half_float_add_unit.sv
